// ===== hdl/integer_to_ascii_formatter_top_assert.svh =====
// Assertion macros for the integer-to-ASCII formatter checker
`ifndef INTEGER_TO_ASCII_FORMATTER_TOP_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define ITOA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ITOA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/itoa_pkg.sv =====
// Shared types, constants and character table for the integer-to-ASCII formatter
`timescale 1ns / 1ps

package itoa_pkg;

    localparam int VALUE_BITS_DEF = 64;
    // decimal digit places for VALUE_BITS_DEF bits: floor(bits * log10(2)) + 1
    localparam int DIGITS_DEF = (VALUE_BITS_DEF * 77) / 256 + 1;

    localparam logic [1:0] ACT_SDEC = 2'd0;
    localparam logic [1:0] ACT_UDEC = 2'd1;
    localparam logic [1:0] ACT_HEX  = 2'd2;
    localparam logic [1:0] ACT_PTR  = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_X     = 8'h78;

    localparam logic [7:0] HEX_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    // commands from the sequencer to the digit unit
    typedef struct packed {
        logic load_dec;
        logic load_hex;
        logic step;
        logic shift;
    } itoa_cmd_t;

endpackage

// ===== hdl/integer_to_ascii_formatter_top.sv =====
// Top level of the integer-to-ASCII formatter: sequencer and output word register
`timescale 1ns / 1ps

// Turns one integer into its ASCII text, most significant character first, one
// output word per character, with last set on the final character. action picks
// signed decimal, unsigned decimal, hex without leading zeros, or "0x" plus hex;
// wide picks a VALUE_BITS-bit operand over the low 32 bits. The block takes one
// input word at a time and drops in_ready until the last character is in the
// output register. Decimal goes through a double-dabble converter that does one
// bit per cycle. Then the digit register is walked one digit place per cycle
// (DIGITS places, 20 at 64 bits), leading zeros skipped; a place that yields a
// character waits while the output is stalled. Prefix characters ('-' or "0x")
// are sent from their own state ahead of the digits.
module integer_to_ascii_formatter_top
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic        wide,
    input  logic [63:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  char_out,
    output logic        last
);

    localparam int DIGITS = (VALUE_BITS * 77) / 256 + 1;
    localparam int RW     = $clog2(DIGITS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CONV = 4'b0010,
        S_PRE  = 4'b0100,
        S_EMIT = 4'b1000
    } state_t;

    // pending prefix characters
    typedef enum logic [1:0] {
        PFX_NONE,
        PFX_MINUS,
        PFX_0X,
        PFX_X
    } pfx_t;

    state_t          state_reg, state_next;
    pfx_t            pfx_reg, pfx_next;
    logic [RW-1:0]   rem_reg, rem_next;
    logic            started_reg, started_next;
    logic            ovalid_reg, ovalid_next;
    logic [7:0]      char_reg, char_next;
    logic            last_reg, last_next;

    itoa_cmd_t       cmd;
    logic            done;
    logic [3:0]      top_nib;

    logic                  accept;
    logic                  slot_free;
    logic [VALUE_BITS-1:0] opnd;
    logic [VALUE_BITS-1:0] mag;
    logic [31:0]           neg32;
    logic                  sign;
    logic                  neg;
    logic                  is_dec;
    logic                  last_digit;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !ovalid_reg || out_ready;

    // operand selection and two's complement magnitude for signed decimal
    assign opnd   = wide ? value[VALUE_BITS-1:0] : VALUE_BITS'(value[31:0]);
    assign neg32  = ~value[31:0] + 32'd1;
    assign sign   = wide ? value[VALUE_BITS-1] : value[31];
    assign neg    = (action == ACT_SDEC) && sign;
    assign mag    = neg ? (wide ? (~opnd + VALUE_BITS'(1)) : VALUE_BITS'(neg32)) : opnd;
    assign is_dec = (action == ACT_SDEC) || (action == ACT_UDEC);

    assign last_digit = (rem_reg == RW'(1));

    always_comb
    begin
        state_next   = state_reg;
        pfx_next     = pfx_reg;
        rem_next     = rem_reg;
        started_next = started_reg;
        ovalid_next  = ovalid_reg && !out_ready;
        char_next    = char_reg;
        last_next    = last_reg;
        cmd          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rem_next     = RW'(DIGITS);
                    started_next = 1'b0;
                    pfx_next     = neg ? PFX_MINUS : ((action == ACT_PTR) ? PFX_0X : PFX_NONE);
                    if (is_dec)
                    begin
                        cmd.load_dec = 1'b1;
                        state_next   = S_CONV;
                    end
                    else
                    begin
                        cmd.load_hex = 1'b1;
                        state_next   = S_PRE;
                    end
                end
            end
            S_CONV:
            begin
                if (done)
                begin
                    state_next = S_PRE;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            S_PRE:
            begin
                if (pfx_reg == PFX_NONE)
                begin
                    state_next = S_EMIT;
                end
                else if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    last_next   = 1'b0;
                    case (pfx_reg)
                        PFX_MINUS:
                        begin
                            char_next = CH_MINUS;
                            pfx_next  = PFX_NONE;
                        end
                        PFX_0X:
                        begin
                            char_next = CH_ZERO;
                            pfx_next  = PFX_X;
                        end
                        default:
                        begin
                            char_next = CH_X;
                            pfx_next  = PFX_NONE;
                        end
                    endcase
                end
            end
            S_EMIT:
            begin
                if (!started_reg && (top_nib == 4'd0) && !last_digit)
                begin
                    // leading zero: drop it without a word
                    cmd.shift = 1'b1;
                    rem_next  = rem_reg - RW'(1);
                end
                else if (slot_free)
                begin
                    cmd.shift    = 1'b1;
                    rem_next     = rem_reg - RW'(1);
                    started_next = 1'b1;
                    ovalid_next  = 1'b1;
                    char_next    = HEX_CHARS[top_nib];
                    last_next    = last_digit;
                    if (last_digit)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pfx_reg     <= PFX_NONE;
            rem_reg     <= '0;
            started_reg <= 1'b0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pfx_reg     <= pfx_next;
            rem_reg     <= rem_next;
            started_reg <= started_next;
            ovalid_reg  <= ovalid_next;
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    itoa_digit_unit #(
        .VALUE_BITS (VALUE_BITS),
        .DIGITS     (DIGITS)
    ) u_digit (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .wide    (wide),
        .mag     (mag),
        .done    (done),
        .top_nib (top_nib)
    );

    assign out_valid = ovalid_reg;
    assign char_out  = char_reg;
    assign last      = last_reg;

endmodule

// ===== hdl/itoa_digit_unit.sv =====
// Digit register with shared add-3/shift step (double dabble) and digit shift-out
`timescale 1ns / 1ps

module itoa_digit_unit
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int DIGITS     = DIGITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  itoa_cmd_t             cmd,
    input  logic                  wide,
    input  logic [VALUE_BITS-1:0] mag,
    output logic                  done,
    output logic [3:0]            top_nib
);

    localparam int DW = DIGITS * 4;
    localparam int CW = $clog2(VALUE_BITS + 1);

    logic [VALUE_BITS-1:0] bin_reg;
    logic [DW-1:0]         dig_reg;
    logic [CW-1:0]         cnt_reg;
    logic [DW-1:0]         corr;

    // add 3 to every BCD nibble that is 5 or more, ahead of the shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            corr[i*4 +: 4] = (dig_reg[i*4 +: 4] >= 4'd5) ? dig_reg[i*4 +: 4] + 4'd3
                                                         : dig_reg[i*4 +: 4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.load_dec)
        begin
            cnt_reg <= wide ? CW'(VALUE_BITS) : CW'(32);
        end
        else if (cmd.step)
        begin
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_dec)
        begin
            // narrow operands are left-aligned so only 32 steps are needed
            bin_reg <= wide ? mag : (mag << (VALUE_BITS - 32));
            dig_reg <= '0;
        end
        else if (cmd.load_hex)
        begin
            dig_reg <= DW'(mag);
        end
        else if (cmd.step)
        begin
            dig_reg <= {corr[DW-2:0], bin_reg[VALUE_BITS-1]};
            bin_reg <= bin_reg << 1;
        end
        else if (cmd.shift)
        begin
            dig_reg <= dig_reg << 4;
        end
    end

    assign done    = (cnt_reg == '0);
    assign top_nib = dig_reg[DW-1 -: 4];

endmodule

// ===== hdl/itoa_checker.sv =====
// Port-level assertion checker for the integer-to-ASCII formatter, bound to the top
`timescale 1ns / 1ps

`include "integer_to_ascii_formatter_top_assert.svh"

module itoa_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  char_out,
    input logic        last
);

    `ITOA_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(char_out) && $stable(last),
        "output word changed while stalled")
    `ITOA_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready,
        "ready stayed high after an input word was taken")
    // a non-final character in the output register means the number is still in progress
    `ITOA_ASSERT_IMP(a_busy_mid_number, out_valid && !last, !in_ready,
        "input ready before the last character")
    `ITOA_ASSERT_IMP(a_last_is_digit, out_valid && last,
        (char_out >= 8'h30 && char_out <= 8'h39) || (char_out >= 8'h61 && char_out <= 8'h66),
        "final character is not a digit")

endmodule

bind integer_to_ascii_formatter_top itoa_checker u_itoa_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for the integer-to-ASCII formatter: directed table, random words, predictor check

module testbench;
    import itoa_pkg::*;

    localparam int OPERAND_BITS = 64;
    localparam int RANDOM_WORDS = 106;
    // the long output hold-off; the block keeps one number in flight, so it stalls its input
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AFTER   = 300;   // characters seen before the hold-off starts
    // covers a full wide decimal plus a random receiver stall
    localparam int DRAIN_CYCLES = 120;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    // one output word as it should come out
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_word_t;

    // directed row; an empty spelling means the predictor supplies the text
    typedef struct {
        logic [1:0]  act;
        logic        wide_op;
        logic [63:0] raw;
        string       spelled;
    } steer_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [1:0]  action    = ACT_SDEC;
    logic        wide      = 1'b0;
    logic [63:0] value     = 64'd0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [7:0]  char_out;
    logic        last;

    char_word_t pending_chars [$];
    int         err_count  = 0;
    int         chars_seen = 0;
    // both sides stop idling while this is set
    bit         quiet      = 1'b0;

    // Directed words: zeros in every mode, the extremes at both widths, the most
    // negative operand at 64 and 32 bits, ignored upper bits in narrow mode, the
    // decimal and hex digit-count boundaries.
    steer_row_t steer_tab [24] = '{
        '{ACT_SDEC, 1'b1, 64'd0,                  "0"},
        '{ACT_UDEC, 1'b0, 64'd0,                  "0"},
        '{ACT_HEX,  1'b1, 64'd0,                  "0"},
        '{ACT_PTR,  1'b1, 64'd0,                  "0x0"},
        '{ACT_SDEC, 1'b1, 64'h8000_0000_0000_0000, "-9223372036854775808"},
        '{ACT_SDEC, 1'b1, 64'h7fff_ffff_ffff_ffff, "9223372036854775807"},
        '{ACT_SDEC, 1'b1, 64'hffff_ffff_ffff_ffff, "-1"},
        '{ACT_UDEC, 1'b1, 64'hffff_ffff_ffff_ffff, "18446744073709551615"},
        '{ACT_HEX,  1'b1, 64'hffff_ffff_ffff_ffff, "ffffffffffffffff"},
        '{ACT_PTR,  1'b1, 64'hffff_ffff_ffff_ffff, "0xffffffffffffffff"},
        '{ACT_SDEC, 1'b0, 64'hffff_ffff_8000_0000, "-2147483648"},
        '{ACT_SDEC, 1'b0, 64'h0000_0000_7fff_ffff, "2147483647"},
        '{ACT_UDEC, 1'b0, 64'h1234_5678_ffff_ffff, "4294967295"},
        '{ACT_HEX,  1'b0, 64'hffff_ffff_0000_0000, "0"},
        '{ACT_PTR,  1'b0, 64'hdead_beef_0000_00a0, "0xa0"},
        '{ACT_HEX,  1'b1, 64'h1000_0000_0000_0000, "1000000000000000"},
        '{ACT_HEX,  1'b1, 64'h0000_0000_0000_000f, "f"},
        '{ACT_UDEC, 1'b1, 64'd10,                 "10"},
        '{ACT_UDEC, 1'b1, 64'd9,                  "9"},
        '{ACT_SDEC, 1'b0, 64'hffff_ffff_ffff_ffff, "-1"},
        '{ACT_PTR,  1'b0, 64'h0000_0000_ffff_ffff, "0xffffffff"},
        '{ACT_HEX,  1'b1, 64'hfedc_ba98_7654_3210, "fedcba9876543210"},
        '{ACT_SDEC, 1'b1, 64'd1000000000000000000, ""},
        '{ACT_UDEC, 1'b1, 64'h0123_4567_89ab_cdef, ""}
    };

    integer_to_ascii_formatter_top #(
        .VALUE_BITS (OPERAND_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .wide      (wide),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_out  (char_out),
        .last      (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // hard stop; several times the slowest legal run
    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        err_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // push characters, last flag on the final one
    function automatic void queue_chars(input logic [7:0] txt [$]);
        for (int i = 0; i < txt.size(); i++)
            pending_chars.push_back('{ch: txt[i], last: (i == txt.size() - 1)});
    endfunction

    function automatic void queue_spelled(input string s);
        logic [7:0] txt [$];
        for (int i = 0; i < s.len(); i++)
            txt.push_back(s[i]);
        queue_chars(txt);
    endfunction

    // Expected text of one operand: sign handling, decimal or hex digits
    function automatic void format_operand(input logic [1:0] act, input logic wide_op,
                                           input logic [63:0] raw);
        int unsigned w;
        int          nibs;
        logic [63:0] mask;
        logic [63:0] v;
        logic [3:0]  nib;
        logic [7:0]  txt [$];
        logic [7:0]  dec [$];
        bit          started;
        w = wide_op ? OPERAND_BITS : 32;
        mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
        v = raw & mask;
        started = 1'b0;
        if (act == ACT_SDEC || act == ACT_UDEC)
        begin
            // negative: minus sign, then the exact unsigned magnitude
            if (act == ACT_SDEC && v[w - 1])
            begin
                txt.push_back(CH_MINUS);
                v = (~v + 64'd1) & mask;
            end
            do
            begin
                dec.push_front(CH_ZERO + 8'(v % 64'd10));
                v = v / 64'd10;
            end
            while (v != 64'd0);
            txt = {txt, dec};
        end
        else
        begin
            if (act == ACT_PTR)
            begin
                txt.push_back(CH_ZERO);
                txt.push_back(CH_X);
            end
            // leading zero nibbles dropped, nibble 0 always printed
            nibs = (w + 3) / 4;
            for (int i = nibs - 1; i >= 0; i--)
            begin
                nib = 4'(v >> (i * 4));
                if (nib != 4'd0 || started || i == 0)
                begin
                    txt.push_back(nib < 4'd10 ? CH_ZERO + 8'(nib)
                                              : CH_LOWER_A + 8'(nib) - 8'd10);
                    started = 1'b1;
                end
            end
        end
        queue_chars(txt);
    endfunction

    // Random operand with a bias toward digit-count and sign boundaries
    function automatic logic [63:0] draw_operand();
        logic [63:0] p;
        int          k;
        p = 64'd1;
        case ($urandom_range(0, 6))
            0: return 64'd0;
            1: return 64'($urandom_range(0, 1000));
            2: return {$urandom, $urandom};
            3:
            begin
                // around a power of ten
                k = $urandom_range(0, 19);
                repeat (k) p = p * 64'd10;
                return p + 64'($urandom_range(0, 2)) - 64'd1;
            end
            4:
            begin
                // around the 64-bit or the 32-bit sign bit
                if ($urandom_range(0, 1) == 0)
                    return 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 2)) - 64'd1;
                return {$urandom, 32'h8000_0000 + 32'($urandom_range(0, 2)) - 32'd1};
            end
            5: return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
    endfunction

    // Offer one input word; the expectation is queued at the accepting edge
    task automatic offer_word(input logic [1:0] act, input logic wide_op,
                              input logic [63:0] raw, input string spelled);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        wide     <= wide_op;
        value    <= raw;
        do
            @(posedge clk);
        while (!in_ready);
        if (spelled.len() != 0)
            queue_spelled(spelled);
        else
            format_operand(act, wide_op, raw);
    endtask

    task automatic take_char(input logic [7:0] got_ch, input logic got_last);
        char_word_t want;
        chars_seen++;
        if (pending_chars.size() == 0)
        begin
            flag_mismatch($sformatf("word %0d with nothing pending: char=%02h last=%0b",
                                    chars_seen, got_ch, got_last));
            return;
        end
        want = pending_chars.pop_front();
        if (got_ch !== want.ch)
            flag_mismatch($sformatf("word %0d char_out=%02h, want %02h",
                                    chars_seen, got_ch, want.ch));
        if (got_last !== want.last)
            flag_mismatch($sformatf("word %0d last=%0b, want %0b",
                                    chars_seen, got_last, want.last));
    endtask

    // Receiver: random stall per word, one long hold-off partway through
    initial
    begin : drain
        int stall;
        bit held;
        held = 1'b0;
        wait (rst_n);
        forever
        begin
            if (!held && chars_seen >= HOLD_AFTER)
            begin
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end
            else
                stall = quiet ? 0 : $urandom_range(0, 13);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            take_char(char_out, last);
        end
    end

    // Stimulus: reset, directed table, random words, then drain and verdict
    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (steer_tab[i])
            offer_word(steer_tab[i].act, steer_tab[i].wide_op, steer_tab[i].raw,
                       steer_tab[i].spelled);

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // a back-to-back stretch with no idling on either side
            quiet = (n >= 50 && n < 70);
            offer_word(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       draw_operand(), "");
        end
        quiet = 1'b0;
        in_valid <= 1'b0;

        while (pending_chars.size() != 0)
            @(posedge clk);
        // catch stray words after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
